[design/pes_pkg.sv]
`timescale 1ns / 1ps
// Package for the motor plant step block: step codes, command word type,
// fixed-point constants and register reset values. No dependencies.
package pes_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [2:0] REG_RESISTANCE = 3'd0;
    localparam logic [2:0] REG_BEMF       = 3'd1;
    localparam logic [2:0] REG_DAMPING    = 3'd2;
    localparam logic [2:0] REG_LOAD       = 3'd3;
    localparam logic [2:0] REG_DT_L       = 3'd4;
    localparam logic [2:0] REG_DT_J       = 3'd5;
    localparam logic [2:0] REG_TIME_STEP  = 3'd6;

    localparam logic [31:0] RST_RESISTANCE = 32'd8388608;
    localparam logic [31:0] RST_BEMF       = 32'd1677722;
    localparam logic [31:0] RST_DAMPING    = 32'd1678;
    localparam logic [31:0] RST_LOAD       = 32'd0;
    localparam logic [31:0] RST_DT_L       = 32'd838861;
    localparam logic [31:0] RST_DT_J       = 32'd838861;
    localparam logic [31:0] RST_TIME_STEP  = 32'd214748;

    localparam logic [31:0] SIN_ONE      = 32'h4000_0000;
    localparam logic [31:0] SIN_C1       = 32'd1686629713;
    localparam logic [31:0] SIN_C3       = 32'd693598669;
    localparam logic [31:0] SIN_C5       = 32'd85569305;
    localparam logic [31:0] SIN_C7       = 32'd5026993;
    localparam logic [31:0] INV_SQRT3    = 32'd9686330;
    localparam logic [31:0] TURN_PER_RAD = 32'd683565276;

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_KW       = 5'd1;
    localparam logic [4:0] ST_SN_SETUP = 5'd2;
    localparam logic [4:0] ST_SN_ZZ    = 5'd3;
    localparam logic [4:0] ST_SN_P7    = 5'd4;
    localparam logic [4:0] ST_SN_P5    = 5'd5;
    localparam logic [4:0] ST_SN_P3    = 5'd6;
    localparam logic [4:0] ST_SN_PZ    = 5'd7;
    localparam logic [4:0] ST_EMF      = 5'd8;
    localparam logic [4:0] ST_CUR_R    = 5'd9;
    localparam logic [4:0] ST_CUR_U    = 5'd10;
    localparam logic [4:0] ST_CUR_D    = 5'd11;
    localparam logic [4:0] ST_BD       = 5'd12;
    localparam logic [4:0] ST_IBETA    = 5'd13;
    localparam logic [4:0] ST_T1       = 5'd14;
    localparam logic [4:0] ST_T2       = 5'd15;
    localparam logic [4:0] ST_TE       = 5'd16;
    localparam logic [4:0] ST_DM       = 5'd17;
    localparam logic [4:0] ST_DJ       = 5'd18;
    localparam logic [4:0] ST_RAD      = 5'd19;
    localparam logic [4:0] ST_TURN     = 5'd20;
    localparam logic [4:0] ST_OUT      = 5'd21;

    localparam logic [1:0] PH_LOAD = 2'd0;
    localparam logic [1:0] PH_PROD = 2'd1;
    localparam logic [1:0] PH_WB   = 2'd2;

    localparam logic [1:0] SH16 = 2'd0;
    localparam logic [1:0] SH24 = 2'd1;
    localparam logic [1:0] SH30 = 2'd2;
    localparam logic [1:0] SH32 = 2'd3;

    typedef struct packed {
        logic       start;
        logic [4:0] step;
        logic [1:0] idx;
        logic [1:0] phase;
        logic       out_load;
    } pes_cmd_t;

    function automatic logic is_mul(input logic [4:0] step);
        logic m;
        case (step)
            ST_KW, ST_SN_ZZ, ST_SN_P7, ST_SN_P5, ST_SN_P3, ST_SN_PZ, ST_EMF,
            ST_CUR_R, ST_CUR_D, ST_IBETA, ST_T1, ST_T2, ST_TE, ST_DM, ST_DJ,
            ST_RAD, ST_TURN: m = 1'b1;
            default: m = 1'b0;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] sin_offset(input logic [1:0] idx);
        logic [31:0] o;
        case (idx)
            2'd0: o = 32'h0000_0000;
            2'd1: o = 32'hAAAA_AAAB;
            2'd2: o = 32'h5555_5555;
            default: o = 32'h4000_0000;
        endcase
        return o;
    endfunction

endpackage

[design/pes_ctrl.sv]
`timescale 1ns / 1ps
// Step sequencer for the motor plant block: walks the multiply and ALU steps.
// Depends on pes_pkg.
module pes_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    output pes_pkg::pes_cmd_t  cmd
);
    import pes_pkg::*;

    logic [4:0] state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic [1:0] phase_reg, phase_next;
    logic       out_valid_reg, out_valid_next;
    logic       start;
    logic       out_load;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        start      = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    start      = 1'b1;
                    state_next = ST_KW;
                    idx_next   = 2'd0;
                    phase_next = PH_LOAD;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                if (is_mul(state_reg) && phase_reg != PH_WB)
                begin
                    phase_next = phase_reg + 2'd1;
                end
                else
                begin
                    phase_next = PH_LOAD;
                    case (state_reg)
                        ST_KW:       state_next = ST_SN_SETUP;
                        ST_SN_SETUP: state_next = ST_SN_ZZ;
                        ST_SN_ZZ:    state_next = ST_SN_P7;
                        ST_SN_P7:    state_next = ST_SN_P5;
                        ST_SN_P5:    state_next = ST_SN_P3;
                        ST_SN_P3:    state_next = ST_SN_PZ;
                        ST_SN_PZ:
                        begin
                            if (idx_reg == 2'd3)
                            begin
                                state_next = ST_EMF;
                                idx_next   = 2'd0;
                            end
                            else
                            begin
                                state_next = ST_SN_SETUP;
                                idx_next   = idx_reg + 2'd1;
                            end
                        end
                        ST_EMF:
                        begin
                            if (idx_reg == 2'd2)
                            begin
                                state_next = ST_CUR_R;
                                idx_next   = 2'd0;
                            end
                            else
                            begin
                                idx_next = idx_reg + 2'd1;
                            end
                        end
                        ST_CUR_R:    state_next = ST_CUR_U;
                        ST_CUR_U:    state_next = ST_CUR_D;
                        ST_CUR_D:
                        begin
                            if (idx_reg == 2'd2)
                            begin
                                state_next = ST_BD;
                            end
                            else
                            begin
                                state_next = ST_CUR_R;
                                idx_next   = idx_reg + 2'd1;
                            end
                        end
                        ST_BD:       state_next = ST_IBETA;
                        ST_IBETA:    state_next = ST_T1;
                        ST_T1:       state_next = ST_T2;
                        ST_T2:       state_next = ST_TE;
                        ST_TE:       state_next = ST_DM;
                        ST_DM:       state_next = ST_DJ;
                        ST_DJ:       state_next = ST_RAD;
                        ST_RAD:      state_next = ST_TURN;
                        ST_TURN:     state_next = ST_OUT;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= 2'd0;
            phase_reg     <= PH_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign cmd.start    = start;
    assign cmd.step     = state_reg;
    assign cmd.idx      = idx_reg;
    assign cmd.phase    = phase_reg;
    assign cmd.out_load = out_load;

endmodule

[design/pes_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the motor plant block: config registers, plant state, shared
// multiplier, sine steps, divide-by-three for the neutral. Depends on pes_pkg.
module pes_datapath #(
    parameter int VW = pes_pkg::VALUE_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pes_pkg::pes_cmd_t   cmd,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic signed [31:0]  phase_a_voltage,
    input  logic signed [31:0]  phase_b_voltage,
    input  logic signed [31:0]  phase_c_voltage,
    output logic [31:0]         rotor_angle,
    output logic signed [31:0]  rotor_speed,
    output logic signed [31:0]  current_a,
    output logic signed [31:0]  current_b,
    output logic signed [31:0]  current_c
);
    import pes_pkg::*;

    localparam int MW = (VW > 32) ? VW : 32;
    localparam int PW = MW + 16;
    localparam int EW = MW + 4;
    localparam int DW = 2 * ((VW + 3) / 2);
    localparam int CW = $clog2(DW / 2 + 1);
    localparam logic signed [VW-1:0] VMAX_V = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN_V = {1'b1, {(VW-1){1'b0}}};

    function automatic logic signed [EW-1:0] ext(input logic signed [VW-1:0] x);
        return EW'(x);
    endfunction

    function automatic logic signed [VW-1:0] sat_e(input logic signed [EW-1:0] x);
        logic signed [VW-1:0] r;
        if (x > EW'(VMAX_V))
            r = VMAX_V;
        else if (x < EW'(VMIN_V))
            r = VMIN_V;
        else
            r = x[VW-1:0];
        return r;
    endfunction

    function automatic logic [31:0] to32(input logic signed [VW-1:0] x);
        logic signed [EW-1:0] e;
        e = EW'(x);
        return e[31:0];
    endfunction

    logic [31:0] res_reg, bemf_reg, damp_reg, load_reg, dtl_reg, dtj_reg, ts_reg;
    logic [31:0] angle_reg, old_reg;
    logic signed [VW-1:0] speed_reg;
    logic signed [VW-1:0] cur_reg [0:2];
    logic signed [VW-1:0] v_reg [0:2];
    logic signed [VW-1:0] emf_reg [0:2];
    logic signed [31:0]   sin_reg [0:3];
    logic signed [VW-1:0] kw_reg, tmp_reg, u_reg, bd_reg, ibeta_reg, t1_reg;
    logic signed [VW-1:0] iq_reg, te_reg, torque_reg, rad_reg;
    logic [30:0] z_reg;
    logic [31:0] z2_reg, p_reg;
    logic [1:0]  q_reg;

    logic [MW-1:0] mm_reg;
    logic [31:0]   mc_reg;
    logic          mneg_reg;
    logic [1:0]    msh_reg;
    logic [PW-1:0] lo_reg, hi_reg;

    logic [DW-1:0] div_reg;
    logic [1:0]    rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          dneg_reg;

    logic [31:0]          out_angle_reg;
    logic [31:0]          out_speed_reg, out_a_reg, out_b_reg, out_c_reg;

    logic signed [VW-1:0] in_a, in_b, in_c;
    logic signed [EW-1:0] sum_e, sum_abs, neutral_e, am_e;
    logic signed [VW-1:0] op_a;
    logic                 op_raw;
    logic [30:0]          op_raw_val;
    logic [31:0]          op_c;
    logic                 op_c_sin;
    logic [1:0]           op_sh;
    logic                 a_neg, c_neg;
    logic [31:0]          c_mag, sin_arg;
    logic [PW:0]          full, r;
    logic                 big;
    logic signed [VW-1:0] sv;
    logic [31:0]          s32, rsub;
    logic [3:0]           dnxt, drem;
    logic [1:0]           dq;
    logic signed [VW-1:0] load_v;

    assign in_a   = sat_e(EW'(phase_a_voltage));
    assign in_b   = sat_e(EW'(phase_b_voltage));
    assign in_c   = sat_e(EW'(phase_c_voltage));
    assign load_v = sat_e(EW'(signed'(load_reg)));
    assign sum_e  = ext(in_a) + ext(in_b) + ext(in_c);
    assign sum_abs = sum_e[EW-1] ? -sum_e : sum_e;
    assign neutral_e = dneg_reg ? -signed'(EW'(div_reg)) : signed'(EW'(div_reg));
    assign sin_arg = old_reg + sin_offset(cmd.idx);

    assign dnxt = {rem_reg, div_reg[DW-1:DW-2]};
    assign dq   = (dnxt >= 4'd9) ? 2'd3 : (dnxt >= 4'd6) ? 2'd2 : (dnxt >= 4'd3) ? 2'd1 : 2'd0;
    assign drem = dnxt - {dq, 1'b0} - {2'b00, dq};

    always_comb
    begin
        op_a       = speed_reg;
        op_raw     = 1'b0;
        op_raw_val = z_reg;
        op_c       = bemf_reg;
        op_c_sin   = 1'b0;
        op_sh      = SH24;
        case (cmd.step)
            ST_KW:    begin op_a = speed_reg; op_c = bemf_reg; end
            ST_SN_ZZ: begin op_raw = 1'b1; op_raw_val = z_reg; op_c = {1'b0, z_reg};
                            op_sh = SH30; end
            ST_SN_P7: begin op_raw = 1'b1; op_raw_val = z2_reg[30:0]; op_c = SIN_C7;
                            op_sh = SH30; end
            ST_SN_P5, ST_SN_P3:
                      begin op_raw = 1'b1; op_raw_val = z2_reg[30:0]; op_c = p_reg;
                            op_sh = SH30; end
            ST_SN_PZ: begin op_raw = 1'b1; op_raw_val = z_reg; op_c = p_reg;
                            op_sh = SH30; end
            ST_EMF:   begin op_a = kw_reg; op_c = sin_reg[cmd.idx]; op_c_sin = 1'b1;
                            op_sh = SH30; end
            ST_CUR_R: begin op_a = cur_reg[cmd.idx]; op_c = res_reg; end
            ST_CUR_D: begin op_a = u_reg; op_c = dtl_reg; end
            ST_IBETA: begin op_a = bd_reg; op_c = INV_SQRT3; end
            ST_T1:    begin op_a = ibeta_reg; op_c = sin_reg[3]; op_c_sin = 1'b1;
                            op_sh = SH30; end
            ST_T2:    begin op_a = cur_reg[0]; op_c = sin_reg[0]; op_c_sin = 1'b1;
                            op_sh = SH30; end
            ST_TE:    begin op_a = iq_reg; op_c = bemf_reg; end
            ST_DM:    begin op_a = speed_reg; op_c = damp_reg; end
            ST_DJ:    begin op_a = torque_reg; op_c = dtj_reg; end
            ST_RAD:   begin op_a = speed_reg; op_c = ts_reg; op_sh = SH32; end
            ST_TURN:  begin op_a = rad_reg; op_c = TURN_PER_RAD; op_sh = SH16; end
            default:  begin op_a = speed_reg; end
        endcase
        a_neg = !op_raw && op_a[VW-1];
        c_neg = op_c_sin && op_c[31];
        am_e  = a_neg ? -ext(op_a) : ext(op_a);
        c_mag = c_neg ? -op_c : op_c;

        full = (PW+1)'(hi_reg) + (PW+1)'(lo_reg >> 16);
        case (msh_reg)
            SH16:    r = full;
            SH24:    r = full >> 8;
            SH30:    r = full >> 14;
            default: r = full >> 16;
        endcase
        big = |r[PW:VW-1];
        if (big)
            sv = mneg_reg ? VMIN_V : VMAX_V;
        else
            sv = mneg_reg ? -signed'(r[VW-1:0]) : signed'(r[VW-1:0]);
        s32  = (r > (PW+1)'(SIN_ONE)) ? SIN_ONE : r[31:0];
        rsub = r[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg    <= RST_RESISTANCE;
            bemf_reg   <= RST_BEMF;
            damp_reg   <= RST_DAMPING;
            load_reg   <= RST_LOAD;
            dtl_reg    <= RST_DT_L;
            dtj_reg    <= RST_DT_J;
            ts_reg     <= RST_TIME_STEP;
            angle_reg  <= '0;
            speed_reg  <= '0;
            cur_reg[0] <= '0;
            cur_reg[1] <= '0;
            cur_reg[2] <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RESISTANCE: res_reg  <= cfg_data;
                    REG_BEMF:       bemf_reg <= cfg_data;
                    REG_DAMPING:    damp_reg <= cfg_data;
                    REG_LOAD:       load_reg <= cfg_data;
                    REG_DT_L:       dtl_reg  <= cfg_data;
                    REG_DT_J:       dtj_reg  <= cfg_data;
                    REG_TIME_STEP:  ts_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.start)
                cnt_reg <= CW'(DW / 2);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
            if (cmd.phase == PH_WB)
            begin
                case (cmd.step)
                    ST_CUR_D: cur_reg[cmd.idx] <= sat_e(ext(cur_reg[cmd.idx]) + ext(sv));
                    ST_DJ:    speed_reg <= sat_e(ext(speed_reg) + ext(sv));
                    ST_TURN:  angle_reg <= mneg_reg ? old_reg - rsub : old_reg + rsub;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            v_reg[0] <= in_a;
            v_reg[1] <= in_b;
            v_reg[2] <= in_c;
            old_reg  <= angle_reg;
            div_reg  <= sum_abs[DW-1:0];
            rem_reg  <= 2'd0;
            dneg_reg <= sum_e[EW-1];
        end
        else if (cnt_reg != '0)
        begin
            div_reg <= {div_reg[DW-3:0], dq};
            rem_reg <= drem[1:0];
        end

        if (is_mul(cmd.step) && cmd.phase == PH_LOAD)
        begin
            mm_reg   <= op_raw ? MW'(op_raw_val) : am_e[MW-1:0];
            mc_reg   <= c_mag;
            mneg_reg <= a_neg ^ c_neg;
            msh_reg  <= op_sh;
        end
        if (cmd.phase == PH_PROD)
        begin
            lo_reg <= PW'(mm_reg) * PW'(mc_reg[15:0]);
            hi_reg <= PW'(mm_reg) * PW'(mc_reg[31:16]);
        end

        if (cmd.step == ST_SN_SETUP)
        begin
            q_reg <= sin_arg[31:30];
            z_reg <= sin_arg[30] ? (SIN_ONE[30:0] - {1'b0, sin_arg[29:0]})
                                 : {1'b0, sin_arg[29:0]};
        end
        if (cmd.step == ST_CUR_U)
            u_reg <= sat_e(ext(v_reg[cmd.idx]) - neutral_e - ext(tmp_reg)
                           - ext(emf_reg[cmd.idx]));
        if (cmd.step == ST_BD)
            bd_reg <= sat_e(ext(cur_reg[1]) - ext(cur_reg[2]));

        if (cmd.phase == PH_WB)
        begin
            case (cmd.step)
                ST_KW:    kw_reg <= sv;
                ST_SN_ZZ: z2_reg <= rsub;
                ST_SN_P7: p_reg <= SIN_C5 - rsub;
                ST_SN_P5: p_reg <= SIN_C3 - rsub;
                ST_SN_P3: p_reg <= SIN_C1 - rsub;
                ST_SN_PZ: sin_reg[cmd.idx] <= q_reg[1] ? -signed'(s32) : signed'(s32);
                ST_EMF:   emf_reg[cmd.idx] <= sv;
                ST_CUR_R: tmp_reg <= sv;
                ST_IBETA: ibeta_reg <= sv;
                ST_T1:    t1_reg <= sv;
                ST_T2:    iq_reg <= sat_e(ext(t1_reg) - ext(sv));
                ST_TE:    te_reg <= sv;
                ST_DM:    torque_reg <= sat_e(ext(te_reg) - ext(sv) - ext(load_v));
                ST_RAD:   rad_reg <= sv;
                default: ;
            endcase
        end

        if (cmd.out_load)
        begin
            out_angle_reg <= angle_reg;
            out_speed_reg <= to32(speed_reg);
            out_a_reg     <= to32(cur_reg[0]);
            out_b_reg     <= to32(cur_reg[1]);
            out_c_reg     <= to32(cur_reg[2]);
        end
    end

    assign rotor_angle = out_angle_reg;
    assign rotor_speed = signed'(out_speed_reg);
    assign current_a   = signed'(out_a_reg);
    assign current_b   = signed'(out_b_reg);
    assign current_c   = signed'(out_c_reg);

endmodule

[design/pmsm_euler_plant_step_top.sv]
`timescale 1ns / 1ps
// Top level of the motor plant step block: sequencer plus datapath.
// A new input word is taken only while the sequencer is idle; all products go
// through the single shared two-32x16 multiplier, one step after another.
// A finished word waits in the output register while the next word is taken.
// Reset clears plant state to zero and the registers to their defaults.
module pmsm_euler_plant_step_top #(
    parameter int VALUE_WIDTH = pes_pkg::VALUE_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] phase_a_voltage,
    input  logic signed [31:0] phase_b_voltage,
    input  logic signed [31:0] phase_c_voltage,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        rotor_angle,
    output logic signed [31:0] rotor_speed,
    output logic signed [31:0] current_a,
    output logic signed [31:0] current_b,
    output logic signed [31:0] current_c,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import pes_pkg::*;

    pes_cmd_t cmd;

    pes_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    pes_datapath #(
        .VW (VALUE_WIDTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .phase_a_voltage (phase_a_voltage),
        .phase_b_voltage (phase_b_voltage),
        .phase_c_voltage (phase_c_voltage),
        .rotor_angle     (rotor_angle),
        .rotor_speed     (rotor_speed),
        .current_a       (current_a),
        .current_b       (current_b),
        .current_c       (current_c)
    );

endmodule
